@@ rtl/tic_pkg.sv @@
// ============================================================================
// tic_pkg: shared constants and types for the triangle incenter unit
// Widths of coordinates, squared distances, fixed-point lengths and sums.
// ============================================================================
`default_nettype none

package tic_pkg;

	localparam int CoordBits   = 12;
	localparam int LenFracBits = 8;
	// Squared distance: dx^2 + dy^2 needs 2*CoordBits+1 bits.
	localparam int D2Bits      = 2 * CoordBits + 1;
	// Radicand after the fraction shift.
	localparam int RadBits     = D2Bits + 2 * LenFracBits;
	// Number of root digits (pairs of radicand bits).
	localparam int RootSteps   = (RadBits + 1) / 2;
	// Root width; the value fits in RootSteps bits.
	localparam int LenBits     = RootSteps;
	// Remainder carries two bits more than the root.
	localparam int RemBits     = LenBits + 2;
	// Perimeter: sum of three lengths.
	localparam int PerimBits   = LenBits + 2;
	// Weighted sum of coordinates.
	localparam int WsumBits    = CoordBits + LenBits + 2;
	// Quotient bits to develop; result never exceeds a coordinate.
	localparam int QuotBits    = CoordBits;
	// Root digits resolved per pipeline stage.
	localparam int SqrtPerStage = 4;
	localparam int SqrtStages   = (RootSteps + SqrtPerStage - 1) / SqrtPerStage;
	// Quotient bits resolved per pipeline stage.
	localparam int DivPerStage  = 2;
	localparam int DivStages    = (QuotBits + DivPerStage - 1) / DivPerStage;

	typedef logic [CoordBits-1:0] coord_t;
	typedef logic [D2Bits-1:0]    d2_t;
	typedef logic [LenBits-1:0]   len_t;

	// One triangle on the input channel.
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by_coord;
		coord_t cx_coord;
		coord_t cy_coord;
	} triangle_t;

	// One incenter on the output channel.
	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		logic   degenerate;
	} incenter_t;

endpackage

`default_nettype wire

@@ rtl/tic_if.sv @@
// ============================================================================
// tic_stream_if: valid/ready channel with a generic payload
// Source drives valid and payload, sink drives ready.
// ============================================================================
`default_nettype none

interface tic_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tic_sqrt.sv @@
// ============================================================================
// tic_sqrt: pipelined fixed-point square root
// Computes floor(sqrt(d2 << 2*LenFracBits)), a few digits per stage.
// ============================================================================
`default_nettype none

module tic_sqrt
	import tic_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           en,
	input  wire d2_t            d2,
	output len_t                root
);

	localparam int Stages = SqrtStages;
	// The radicand is padded to a whole number of digit pairs.
	localparam int RadW   = 2 * RootSteps;

	logic [RadW-1:0]    rad_s [Stages+1];
	logic [LenBits-1:0] root_s [Stages+1];
	logic [RemBits-1:0] rem_s [Stages+1];

	assign rad_s[0]  = RadW'({d2, {(2*LenFracBits){1'b0}}});
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		logic [RadW-1:0]    rad_n;
		logic [LenBits-1:0] root_n;
		logic [RemBits-1:0] rem_n;

		// A handful of restoring root steps on the current digit pairs.
		always_comb begin
			logic [RemBits-1:0] trial;
			logic [RemBits-1:0] shifted;
			int step;
			rad_n  = rad_s[g];
			root_n = root_s[g];
			rem_n  = rem_s[g];
			for (int k = 0; k < SqrtPerStage; k++) begin
				step = g * SqrtPerStage + k;
				if (step < RootSteps) begin
					shifted = {rem_n[RemBits-3:0], rad_n[RadW-1 -: 2]};
					trial   = {root_n[LenBits-1:0], 2'b01};
					rad_n   = {rad_n[RadW-3:0], 2'b00};
					if (shifted >= trial) begin
						rem_n  = shifted - trial;
						root_n = {root_n[LenBits-2:0], 1'b1};
					end else begin
						rem_n  = shifted;
						root_n = {root_n[LenBits-2:0], 1'b0};
					end
				end
			end
		end

		logic [RadW-1:0]    rad_q;
		logic [LenBits-1:0] root_q;
		logic [RemBits-1:0] rem_q;

		// Stage register, advanced when the pipeline moves.
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q  <= rad_n;
				root_q <= root_n;
				rem_q  <= rem_n;
			end
		end

		assign rad_s[g+1]  = rad_q;
		assign root_s[g+1] = root_q;
		assign rem_s[g+1]  = rem_q;
	end

	assign root = root_s[Stages];

endmodule

`default_nettype wire

@@ rtl/tic_div.sv @@
// ============================================================================
// tic_div: pipelined restoring divider
// Floors a weighted sum by the perimeter, a few quotient bits per stage.
// ============================================================================
`default_nettype none

module tic_div
	import tic_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [WsumBits-1:0]  num,
	input  wire logic [PerimBits-1:0] den,
	output coord_t                    quot
);

	localparam int Stages = DivStages;
	localparam int RBits  = PerimBits + 1;

	logic [WsumBits-1:0]  num_s [Stages+1];
	logic [PerimBits-1:0] den_s [Stages+1];
	logic [RBits-1:0]     rem_s [Stages+1];
	logic [QuotBits-1:0]  quo_s [Stages+1];

	// The quotient is below 2^QuotBits, so the upper numerator bits seed
	// the remainder (they are smaller than the divisor).
	assign num_s[0] = num;
	assign den_s[0] = den;
	assign rem_s[0] = RBits'(num >> QuotBits);
	assign quo_s[0] = '0;

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		logic [RBits-1:0]    rem_n;
		logic [QuotBits-1:0] quo_n;

		// Shift in the next numerator bit and try one subtraction per bit.
		always_comb begin
			logic [RBits-1:0] sh;
			int bitpos;
			rem_n = rem_s[g];
			quo_n = quo_s[g];
			for (int k = 0; k < DivPerStage; k++) begin
				bitpos = QuotBits - 1 - (g * DivPerStage + k);
				if (bitpos >= 0) begin
					sh = {rem_n[RBits-2:0], num_s[g][bitpos]};
					if (sh >= {1'b0, den_s[g]}) begin
						rem_n = sh - {1'b0, den_s[g]};
						quo_n = {quo_n[QuotBits-2:0], 1'b1};
					end else begin
						rem_n = sh;
						quo_n = {quo_n[QuotBits-2:0], 1'b0};
					end
				end
			end
		end

		logic [WsumBits-1:0]  num_q;
		logic [PerimBits-1:0] den_q;
		logic [RBits-1:0]     rem_q;
		logic [QuotBits-1:0]  quo_q;

		// Stage register.
		always_ff @(posedge clk) begin
			if (en) begin
				num_q <= num_s[g];
				den_q <= den_s[g];
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
		end

		assign num_s[g+1] = num_q;
		assign den_s[g+1] = den_q;
		assign rem_s[g+1] = rem_q;
		assign quo_s[g+1] = quo_q;
	end

	assign quot = quo_s[Stages];

endmodule

`default_nettype wire

@@ rtl/triangle_incenter_unit.sv @@
// ============================================================================
// triangle_incenter_unit: incenter of a triangle with integer vertices
// Side lengths by pipelined roots, weighted sums, then a pipelined divide.
// ============================================================================
// Depth: 3 + SqrtStages + 1 + DivStages register stages (16 at 12-bit
// coordinates).
// Throughput: one triangle per cycle; the whole pipeline holds on a stall.
// The output register takes a new result whenever it is empty or taken.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module triangle_incenter_unit
	import tic_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	tic_stream_if.sink   in_ch,
	tic_stream_if.source out_ch
);

	localparam int Depth = 2 + SqrtStages + 1 + DivStages + 1;

	// Global enable: the pipeline moves when the output slot can take data.
	logic en;
	logic [Depth-1:0] vld_q;

	assign en          = !vld_q[Depth-1] || out_ch.ready;
	assign in_ch.ready = en;

	// Valid bits travel alongside the payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_ch.valid};
		end
	end

	// Stage 1: capture the vertices and form absolute differences.
	coord_t ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	coord_t dxa_s1, dya_s1, dxb_s1, dyb_s1, dxc_s1, dyc_s1;

	function automatic coord_t adiff(coord_t p, coord_t q);
		return (p >= q) ? p - q : q - p;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= in_ch.data.ax;
			ay_s1  <= in_ch.data.ay;
			bx_s1  <= in_ch.data.bx;
			by_s1  <= in_ch.data.by_coord;
			cx_s1  <= in_ch.data.cx_coord;
			cy_s1  <= in_ch.data.cy_coord;
			dxa_s1 <= adiff(in_ch.data.bx, in_ch.data.cx_coord);
			dya_s1 <= adiff(in_ch.data.by_coord, in_ch.data.cy_coord);
			dxb_s1 <= adiff(in_ch.data.ax, in_ch.data.cx_coord);
			dyb_s1 <= adiff(in_ch.data.ay, in_ch.data.cy_coord);
			dxc_s1 <= adiff(in_ch.data.ax, in_ch.data.bx);
			dyc_s1 <= adiff(in_ch.data.ay, in_ch.data.by_coord);
		end
	end

	// Stage 2: squared side lengths.
	d2_t d2a_s2, d2b_s2, d2c_s2;
	coord_t ax_s2, ay_s2, bx_s2, by_s2, cx_s2, cy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			d2a_s2 <= D2Bits'(dxa_s1) * D2Bits'(dxa_s1) + D2Bits'(dya_s1) * D2Bits'(dya_s1);
			d2b_s2 <= D2Bits'(dxb_s1) * D2Bits'(dxb_s1) + D2Bits'(dyb_s1) * D2Bits'(dyb_s1);
			d2c_s2 <= D2Bits'(dxc_s1) * D2Bits'(dxc_s1) + D2Bits'(dyc_s1) * D2Bits'(dyc_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			bx_s2  <= bx_s1;
			by_s2  <= by_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
		end
	end

	// Root stages: three units in lockstep.
	len_t la, lb, lc;

	tic_sqrt u_sqrt_a (.clk(clk), .en(en), .d2(d2a_s2), .root(la));
	tic_sqrt u_sqrt_b (.clk(clk), .en(en), .d2(d2b_s2), .root(lb));
	tic_sqrt u_sqrt_c (.clk(clk), .en(en), .d2(d2c_s2), .root(lc));

	// Vertex delay line matching the root latency.
	coord_t vtx_dly [SqrtStages+1][6];

	assign vtx_dly[0][0] = ax_s2;
	assign vtx_dly[0][1] = ay_s2;
	assign vtx_dly[0][2] = bx_s2;
	assign vtx_dly[0][3] = by_s2;
	assign vtx_dly[0][4] = cx_s2;
	assign vtx_dly[0][5] = cy_s2;

	for (genvar g = 0; g < SqrtStages; g++) begin : g_vdly
		coord_t tap_q [6];
		always_ff @(posedge clk) begin
			if (en) begin
				tap_q <= vtx_dly[g];
			end
		end
		assign vtx_dly[g+1] = tap_q;
	end

	// Weighted-sum stage: one product per vertex coordinate.
	logic [WsumBits-1:0]  wx_s3, wy_s3;
	logic [PerimBits-1:0] perim_s3;
	coord_t               ax_s3, ay_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s3 <= WsumBits'(vtx_dly[SqrtStages][0]) * WsumBits'(la)
				+ WsumBits'(vtx_dly[SqrtStages][2]) * WsumBits'(lb)
				+ WsumBits'(vtx_dly[SqrtStages][4]) * WsumBits'(lc);
			wy_s3 <= WsumBits'(vtx_dly[SqrtStages][1]) * WsumBits'(la)
				+ WsumBits'(vtx_dly[SqrtStages][3]) * WsumBits'(lb)
				+ WsumBits'(vtx_dly[SqrtStages][5]) * WsumBits'(lc);
			perim_s3 <= PerimBits'(la) + PerimBits'(lb) + PerimBits'(lc);
			ax_s3 <= vtx_dly[SqrtStages][0];
			ay_s3 <= vtx_dly[SqrtStages][1];
		end
	end

	// Divide stages; a zero perimeter yields garbage that is replaced later.
	coord_t qx, qy;

	tic_div u_div_x (.clk(clk), .en(en), .num(wx_s3), .den(perim_s3), .quot(qx));
	tic_div u_div_y (.clk(clk), .en(en), .num(wy_s3), .den(perim_s3), .quot(qy));

	// Side delay line for the fallback vertex and the degenerate flag.
	coord_t fx_dly [DivStages+1];
	coord_t fy_dly [DivStages+1];
	logic   dg_dly [DivStages+1];

	assign fx_dly[0] = ax_s3;
	assign fy_dly[0] = ay_s3;
	assign dg_dly[0] = (perim_s3 == '0);

	for (genvar g = 0; g < DivStages; g++) begin : g_fdly
		coord_t fx_q, fy_q;
		logic   dg_q;
		always_ff @(posedge clk) begin
			if (en) begin
				fx_q <= fx_dly[g];
				fy_q <= fy_dly[g];
				dg_q <= dg_dly[g];
			end
		end
		assign fx_dly[g+1] = fx_q;
		assign fy_dly[g+1] = fy_q;
		assign dg_dly[g+1] = dg_q;
	end

	// Output register.
	coord_t cxo_q, cyo_q;
	logic   dgo_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cxo_q <= dg_dly[DivStages] ? fx_dly[DivStages] : qx;
			cyo_q <= dg_dly[DivStages] ? fy_dly[DivStages] : qy;
			dgo_q <= dg_dly[DivStages];
		end
	end

	assign out_ch.valid           = vld_q[Depth-1];
	assign out_ch.data.center_x   = cxo_q;
	assign out_ch.data.center_y   = cyo_q;
	assign out_ch.data.degenerate = dgo_q;

	// A held result must not change while the sink stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed during a stall");

	// The input side is ready exactly when the pipeline advances.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready))
		else $error("input ready out of step with the pipeline");

	// All valid bits hold while the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

@@ tb/triangle_incenter_unit_tb.sv @@
// ============================================================================
// triangle_incenter_unit_tb: self-checking bench for the triangle incenter unit
// Sends directed and random triangles through the valid/ready channel, predicts
// each incenter with fixed-point side lengths and floored quotients, and
// compares every output transfer in order. Both sides idle at random.
// ============================================================================
`default_nettype none

module triangle_incenter_unit_tb;
	import tic_pkg::*;

	localparam int IdleLimit = 4000;

	logic clk;
	logic arst_n;

	tic_stream_if #(.payload_t(triangle_t)) in_ch ();
	tic_stream_if #(.payload_t(incenter_t)) out_ch ();

	triangle_incenter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	incenter_t expected_centers[$];
	int        error_count;
	int        burst_left;
	bit        steady_send;
	int        stall_mode;
	int        idle_cycles;

	// Clock with a period of 8.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Floor of sqrt(d2) with LenFracBits fraction bits, one root digit per pass.
	function automatic longint unsigned fixed_side(longint unsigned d2);
		longint unsigned root;
		longint unsigned rem;
		longint unsigned trial;
		longint unsigned digits;
		int              pos;
		root = 0;
		rem  = 0;
		for (int pair = 16 + LenFracBits; pair >= 0; pair--) begin
			pos    = 2 * pair - 2 * LenFracBits;
			digits = (pos >= 0) ? ((d2 >> pos) & 64'd3) : 64'd0;
			rem    = (rem << 2) | digits;
			trial  = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint unsigned side_between(coord_t x0, coord_t y0,
			coord_t x1, coord_t y1);
		longint unsigned dx;
		longint unsigned dy;
		dx = (x0 >= x1) ? longint'(x0 - x1) : longint'(x1 - x0);
		dy = (y0 >= y1) ? longint'(y0 - y1) : longint'(y1 - y0);
		return fixed_side(dx * dx + dy * dy);
	endfunction

	// Incenter: vertices weighted by opposite side lengths over the perimeter.
	function automatic incenter_t predict_incenter(triangle_t t);
		longint unsigned la;
		longint unsigned lb;
		longint unsigned lc;
		longint unsigned perim;
		incenter_t       r;
		la    = side_between(t.bx, t.by_coord, t.cx_coord, t.cy_coord);
		lb    = side_between(t.ax, t.ay, t.cx_coord, t.cy_coord);
		lc    = side_between(t.ax, t.ay, t.bx, t.by_coord);
		perim = la + lb + lc;
		if (perim == 0) begin
			r.center_x   = t.ax;
			r.center_y   = t.ay;
			r.degenerate = 1'b1;
		end else begin
			r.center_x = coord_t'((t.ax * la + t.bx * lb + t.cx_coord * lc) / perim);
			r.center_y = coord_t'((t.ay * la + t.by_coord * lb + t.cy_coord * lc) / perim);
			r.degenerate = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// Send one triangle; if not steady, the sender runs in bursts with random gaps.
	task automatic send_triangle(triangle_t t);
		bit hit;
		int gap;
		if (!steady_send && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap        = $urandom_range(0, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data  <= t;
		hit = 1'b0;
		while (!hit) begin
			@(negedge clk);
			hit = in_ch.ready;
			if (hit) expected_centers.push_back(predict_incenter(t));
			@(posedge clk);
		end
	endtask

	task automatic idle_sender();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		idle_sender();
		while (expected_centers.size() > 0) @(posedge clk);
	endtask

	function automatic triangle_t make_triangle(int x0, int y0, int x1, int y1,
			int x2, int y2);
		triangle_t t;
		t.ax = coord_t'(x0);
		t.ay = coord_t'(y0);
		t.bx = coord_t'(x1);
		t.by_coord = coord_t'(y1);
		t.cx_coord = coord_t'(x2);
		t.cy_coord = coord_t'(y2);
		return t;
	endfunction

	// Extremes, coincident points, collinear and pairwise coincident vertices.
	task automatic test_directed();
		send_triangle(make_triangle(0, 0, 0, 0, 0, 0));
		send_triangle(make_triangle(4095, 4095, 4095, 4095, 4095, 4095));
		send_triangle(make_triangle(1234, 567, 1234, 567, 1234, 567));
		send_triangle(make_triangle(0, 0, 4095, 0, 0, 4095));
		send_triangle(make_triangle(4095, 4095, 0, 4095, 4095, 0));
		send_triangle(make_triangle(0, 0, 4095, 4095, 0, 4095));
		send_triangle(make_triangle(0, 4095, 4095, 0, 4095, 4095));
		send_triangle(make_triangle(0, 0, 2048, 2048, 4095, 4095));
		send_triangle(make_triangle(0, 0, 0, 0, 4095, 4095));
		send_triangle(make_triangle(100, 100, 100, 100, 101, 100));
		send_triangle(make_triangle(0, 0, 1, 0, 0, 1));
		send_triangle(make_triangle(4095, 0, 4094, 0, 4095, 1));
		send_triangle(make_triangle(10, 20, 30, 20, 50, 20));
		send_triangle(make_triangle(7, 9, 7, 300, 7, 4000));
		send_triangle(make_triangle(2730, 1365, 1365, 2730, 4095, 4095));
		send_triangle(make_triangle(3000, 0, 0, 3000, 3000, 3000));
		wait_drained();
	endtask

	// Mostly well-formed triangles of varied sizes, some degenerate shapes.
	task automatic test_random(int count);
		triangle_t t;
		int        kind;
		int        bx0;
		int        by0;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			t    = triangle_t'($bits(triangle_t)'({$urandom, $urandom, $urandom}));
			if (kind < 3) begin
				bx0 = $urandom_range(0, 4031);
				by0 = $urandom_range(0, 4031);
				t = make_triangle(bx0 + $urandom_range(0, 63), by0 + $urandom_range(0, 63),
					bx0 + $urandom_range(0, 63), by0 + $urandom_range(0, 63),
					bx0 + $urandom_range(0, 63), by0 + $urandom_range(0, 63));
			end else if (kind == 3) begin
				t.bx = t.ax;
				t.by_coord = t.ay;
				t.cx_coord = t.ax;
				t.cy_coord = t.ay;
			end else if (kind == 4) begin
				t.cx_coord = t.bx;
				t.cy_coord = t.by_coord;
			end else if (kind == 5) begin
				t.by_coord = t.ay;
				t.cy_coord = t.ay;
			end
			send_triangle(t);
			if (i == count / 2) wait_drained();
		end
	endtask

	// A stretch with no gaps on either side at full rate.
	task automatic test_back_to_back(int count);
		steady_send = 1'b1;
		stall_mode  = 0;
		for (int i = 0; i < count; i++)
			send_triangle(triangle_t'($bits(triangle_t)'({$urandom, $urandom, $urandom})));
		steady_send = 1'b0;
		stall_mode  = 1;
	endtask

	// Receiver stalls: never, or random at one of two densities, switched every so often.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= ($urandom_range(0, 7) < 3);
			endcase
			if (stall_mode != 0 && $urandom_range(0, 63) == 0)
				stall_mode = $urandom_range(1, 2);
		end
	end

	// Each output transfer is checked against the oldest expectation.
	always @(negedge clk) begin
		incenter_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_centers.size() == 0) begin
				$display("output transfer with nothing expected");
				error_count++;
			end else begin
				want = expected_centers.pop_front();
				if (out_ch.data.center_x !== want.center_x)
					report_mismatch("center_x", out_ch.data.center_x, want.center_x);
				if (out_ch.data.center_y !== want.center_y)
					report_mismatch("center_y", out_ch.data.center_y, want.center_y);
				if (out_ch.data.degenerate !== want.degenerate)
					report_mismatch("degenerate", out_ch.data.degenerate, want.degenerate);
			end
		end
	end

	// Watchdog over cycles in which no transfer happens on either channel.
	always @(negedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog expired");
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		burst_left  = 0;
		steady_send = 1'b0;
		stall_mode  = 1;
		idle_cycles = 0;
		arst_n      = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(900);
		test_back_to_back(100);
		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0 && expected_centers.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
